@@ hw/rtl/joint_feedback_frame_deframer_defines.svh @@
// Assertion macros shared by the joint feedback frame deframer RTL.
`ifndef JOINT_FEEDBACK_FRAME_DEFRAMER_DEFINES_SVH
`define JOINT_FEEDBACK_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define JFFD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define JFFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/jffd_pkg.sv @@
// Package with the frame constants and types of the joint feedback frame deframer.
`timescale 1ns / 1ps

package jffd_pkg;

    localparam int FRAME_BYTES  = 14;
    localparam int JOINT_COUNT  = 6;
    localparam int ANGLE_FIELDS = 6;

    localparam logic [7:0] HEADER_RESET = 8'hAA;

    typedef logic [7:0]         byte_t;
    typedef logic signed [15:0] angle_t;
    typedef logic [3:0]         count_t;

    localparam count_t FRAME_COUNT = count_t'(FRAME_BYTES);

endpackage

@@ hw/rtl/joint_feedback_frame_deframer.sv @@
// Joint feedback frame deframer: sliding 14-byte window, header and checksum check.
`timescale 1ns / 1ps
`include "joint_feedback_frame_deframer_defines.svh"

// Usage:
// Input channel: one received serial byte per word on rx_byte, moved when
// in_valid is high and in_stall is low. Output channel: one word of six
// signed joint angles, moved when out_valid is high and out_stall is low.
// The header byte is written through cfg_wr_en / cfg_wr_data while idle.
// A frame is [header][12 data bytes][checksum], checksum being the low
// eight bits of the sum of the first 13 bytes; angle j is data bytes 2j
// (low) and 2j+1 (high). After a good frame, 14 new bytes are needed.
// Throughput is one byte per cycle while in_stall is low: the window shift
// and the 13-byte adder tree sit between the window register and the
// output register, into which an accepted frame's angles are registered.
// When the receiver stalls, the waiting result holds and one more result
// can land in a skid register; in_stall rises only while that skid
// register is full. Reset clears the byte count, both output valids and
// sets the header register to 0xAA; the window itself needs no clearing.
module joint_feedback_frame_deframer (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  jffd_pkg::byte_t       cfg_wr_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  jffd_pkg::byte_t       rx_byte,
    output logic                  out_valid,
    input  logic                  out_stall,
    output jffd_pkg::angle_t      angle_0,
    output jffd_pkg::angle_t      angle_1,
    output jffd_pkg::angle_t      angle_2,
    output jffd_pkg::angle_t      angle_3,
    output jffd_pkg::angle_t      angle_4,
    output jffd_pkg::angle_t      angle_5
);

    localparam int LAST = jffd_pkg::FRAME_BYTES - 1;

    jffd_pkg::byte_t  header_reg;
    jffd_pkg::byte_t  window_reg [jffd_pkg::FRAME_BYTES];
    jffd_pkg::count_t fresh_count_reg;
    jffd_pkg::count_t fresh_count_next;
    jffd_pkg::count_t count_inc;

    logic             out_valid_reg;
    logic             skid_valid_reg;
    jffd_pkg::angle_t out_angle_reg  [jffd_pkg::ANGLE_FIELDS];
    jffd_pkg::angle_t skid_angle_reg [jffd_pkg::ANGLE_FIELDS];
    jffd_pkg::angle_t frame_angle    [jffd_pkg::ANGLE_FIELDS];

    jffd_pkg::byte_t  sum_l1 [7];
    jffd_pkg::byte_t  sum_l2 [4];
    jffd_pkg::byte_t  sum_l3 [2];
    jffd_pkg::byte_t  frame_sum;

    logic in_fire;
    logic out_fire;
    logic frame_hit;

    assign in_stall = skid_valid_reg;
    assign in_fire  = in_valid && !skid_valid_reg;
    assign out_fire = out_valid_reg && !out_stall;

    // After the shift the candidate frame is window entries 1..13 followed by
    // the incoming byte, so the check works on the old window directly.
    always_comb
    begin
        for (int i = 0; i < 6; i++)
        begin
            sum_l1[i] = window_reg[1 + 2 * i] + window_reg[2 + 2 * i];
        end
        sum_l1[6] = window_reg[LAST];
        for (int i = 0; i < 3; i++)
        begin
            sum_l2[i] = sum_l1[2 * i] + sum_l1[2 * i + 1];
        end
        sum_l2[3] = sum_l1[6];
        sum_l3[0] = sum_l2[0] + sum_l2[1];
        sum_l3[1] = sum_l2[2] + sum_l2[3];
        frame_sum = sum_l3[0] + sum_l3[1];
    end

    always_comb
    begin
        for (int j = 0; j < jffd_pkg::ANGLE_FIELDS; j++)
        begin
            if (j < jffd_pkg::JOINT_COUNT)
            begin
                frame_angle[j] = {window_reg[3 + 2 * j], window_reg[2 + 2 * j]};
            end
            else
            begin
                frame_angle[j] = '0;
            end
        end
    end

    always_comb
    begin
        if (fresh_count_reg < jffd_pkg::FRAME_COUNT)
        begin
            count_inc = fresh_count_reg + 4'd1;
        end
        else
        begin
            count_inc = fresh_count_reg;
        end
        frame_hit = in_fire && (count_inc == jffd_pkg::FRAME_COUNT)
                    && (window_reg[1] == header_reg) && (frame_sum == rx_byte);
        priority if (frame_hit)
        begin
            fresh_count_next = '0;
        end
        else if (in_fire)
        begin
            fresh_count_next = count_inc;
        end
        else
        begin
            fresh_count_next = fresh_count_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            for (int i = 0; i < LAST; i++)
            begin
                window_reg[i] <= window_reg[i + 1];
            end
            window_reg[LAST] <= rx_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg      <= jffd_pkg::HEADER_RESET;
            fresh_count_reg <= '0;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                header_reg <= cfg_wr_data;
            end
            fresh_count_reg <= fresh_count_next;
            priority if (skid_valid_reg)
            begin
                if (out_fire)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (out_valid_reg && !out_fire)
            begin
                skid_valid_reg <= frame_hit;
            end
            else
            begin
                out_valid_reg <= frame_hit;
            end
        end
    end

    // Payload moves: skid to output when the output drains, otherwise a new
    // frame goes to whichever register is free.
    always_ff @(posedge clk)
    begin
        priority if (skid_valid_reg)
        begin
            if (out_fire)
            begin
                out_angle_reg <= skid_angle_reg;
            end
        end
        else if (out_valid_reg && !out_fire)
        begin
            if (frame_hit)
            begin
                skid_angle_reg <= frame_angle;
            end
        end
        else
        begin
            if (frame_hit)
            begin
                out_angle_reg <= frame_angle;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign angle_0   = out_angle_reg[0];
    assign angle_1   = out_angle_reg[1];
    assign angle_2   = out_angle_reg[2];
    assign angle_3   = out_angle_reg[3];
    assign angle_4   = out_angle_reg[4];
    assign angle_5   = out_angle_reg[5];

    `JFFD_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg,
        "skid register holds a word while the output register is empty")
    `JFFD_ASSERT_NOW(a_count_range, 1'b1, fresh_count_reg <= jffd_pkg::FRAME_COUNT,
        "fresh byte count passed the frame length")
    `JFFD_ASSERT_NEXT(a_hit_clears_count, frame_hit, fresh_count_reg == '0,
        "accepted frame did not clear the fresh byte count")
    `JFFD_ASSERT_NEXT(a_hit_gives_word, frame_hit, out_valid_reg,
        "accepted frame produced no output word")

endmodule

@@ verif/tb_top.sv @@
// Testbench for the joint feedback frame deframer: random traffic, live prediction, scoreboard.
`timescale 1ns / 1ps

module tb_top;

    localparam int STALL_LIMIT = 4000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASE_BYTES = 140;

    typedef struct packed {
        jffd_pkg::angle_t [jffd_pkg::ANGLE_FIELDS-1:0] angle;
    } angle_word_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    jffd_pkg::byte_t cfg_wr_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    jffd_pkg::byte_t rx_byte = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    jffd_pkg::angle_t angle_0;
    jffd_pkg::angle_t angle_1;
    jffd_pkg::angle_t angle_2;
    jffd_pkg::angle_t angle_3;
    jffd_pkg::angle_t angle_4;
    jffd_pkg::angle_t angle_5;

    // Bytes waiting to be sent, and angle words the deframer still owes us.
    jffd_pkg::byte_t byte_queue[$];
    angle_word_t angle_expect[$];

    // Shadow copy of the deframer state.
    jffd_pkg::byte_t header_reg = jffd_pkg::HEADER_RESET;
    jffd_pkg::byte_t rx_window [jffd_pkg::FRAME_BYTES];
    int fresh_bytes = 0;

    int unsigned src_idle_pct = 0;
    int unsigned rcv_stall_pct = 0;
    int error_count = 0;
    int idle_cycles = 0;

    joint_feedback_frame_deframer u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .angle_0    (angle_0),
        .angle_1    (angle_1),
        .angle_2    (angle_2),
        .angle_3    (angle_3),
        .angle_4    (angle_4),
        .angle_5    (angle_5)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Appends one byte to the end of the send queue.
    function automatic void queue_byte(input jffd_pkg::byte_t b);
        byte_queue = {byte_queue, b};
    endfunction

    // Slide one byte into the shadow window and queue an angle word when the
    // window holds a complete, fresh frame with a matching header and checksum.
    function automatic void track_rx_byte(input jffd_pkg::byte_t b);
        angle_word_t w;
        jffd_pkg::byte_t sum;
        for (int k = 0; k < jffd_pkg::FRAME_BYTES - 1; k++)
            rx_window[k] = rx_window[k + 1];
        rx_window[jffd_pkg::FRAME_BYTES - 1] = b;
        if (fresh_bytes < jffd_pkg::FRAME_BYTES)
            fresh_bytes++;
        if (fresh_bytes == jffd_pkg::FRAME_BYTES && rx_window[0] == header_reg)
        begin
            sum = '0;
            for (int k = 0; k < jffd_pkg::FRAME_BYTES - 1; k++)
                sum += rx_window[k];
            if (sum == rx_window[jffd_pkg::FRAME_BYTES - 1])
            begin
                for (int j = 0; j < jffd_pkg::ANGLE_FIELDS; j++)
                    w.angle[j] = (j < jffd_pkg::JOINT_COUNT) ?
                                 {rx_window[2 + 2 * j], rx_window[1 + 2 * j]} : '0;
                angle_expect = {angle_expect, w};
                fresh_bytes = 0;
            end
        end
    endfunction

    task automatic queue_frame(input jffd_pkg::byte_t hdr, input angle_word_t ang,
                               input bit sum_ok);
        jffd_pkg::byte_t sum;
        sum = hdr;
        queue_byte(hdr);
        for (int j = 0; j < jffd_pkg::ANGLE_FIELDS; j++)
        begin
            queue_byte(ang.angle[j][7:0]);
            queue_byte(ang.angle[j][15:8]);
            sum += ang.angle[j][7:0];
            sum += ang.angle[j][15:8];
        end
        if (!sum_ok)
            sum = sum ^ jffd_pkg::byte_t'($urandom_range(255, 1));
        queue_byte(sum);
    endtask

    // Mostly good frames with random content; the rest are bad checksums,
    // wrong headers, loose noise and frames cut short.
    task automatic queue_random_traffic(input int n_bytes);
        angle_word_t ang;
        jffd_pkg::byte_t b;
        int len;
        while (byte_queue.size() < n_bytes)
        begin
            for (int j = 0; j < jffd_pkg::ANGLE_FIELDS; j++)
                for (int h = 0; h < 2; h++)
                begin
                    case ($urandom_range(7, 0))
                        0: b = 8'h00;
                        1: b = 8'hFF;
                        2: b = 8'h80;
                        3: b = 8'h7F;
                        4: b = header_reg;
                        default: b = jffd_pkg::byte_t'($urandom_range(255, 0));
                    endcase
                    ang.angle[j][8 * h +: 8] = b;
                end
            case ($urandom_range(9, 0))
                6: queue_frame(header_reg, ang, 1'b0);
                7: queue_frame(header_reg ^ jffd_pkg::byte_t'($urandom_range(255, 1)),
                               ang, 1'b1);
                8:
                begin
                    len = $urandom_range(5, 1);
                    repeat (len)
                        queue_byte(($urandom_range(3, 0) == 0) ? header_reg :
                                   jffd_pkg::byte_t'($urandom_range(255, 0)));
                end
                9:
                begin
                    len = $urandom_range(12, 1);
                    queue_byte(header_reg);
                    repeat (len)
                        queue_byte(jffd_pkg::byte_t'($urandom_range(255, 0)));
                end
                default: queue_frame(header_reg, ang, 1'b1);
            endcase
        end
    endtask

    // Returns on a falling edge once every byte is in and every word is out,
    // after a further tail wait for anything still in the pipeline.
    task automatic wait_drained();
        do
            @(negedge clk);
        while (byte_queue.size() != 0 || in_valid || angle_expect.size() != 0);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    task automatic write_header(input jffd_pkg::byte_t value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        header_reg = value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || !in_stall)
        begin
            if (byte_queue.size() != 0 && $urandom_range(99, 0) >= src_idle_pct)
            begin
                in_valid <= 1'b1;
                rx_byte <= byte_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(posedge clk)
        out_stall <= rst_n && ($urandom_range(99, 0) < rcv_stall_pct);

    always @(posedge clk)
        if (rst_n && in_valid && !in_stall)
            track_rx_byte(rx_byte);

    always @(posedge clk)
    begin : result_check
        angle_word_t seen;
        angle_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            seen.angle = {angle_5, angle_4, angle_3, angle_2, angle_1, angle_0};
            if (angle_expect.size() == 0)
            begin
                if (error_count < 10)
                    $display("Unexpected word at %0t: %h", $realtime, seen);
                error_count++;
            end
            else
            begin
                want = angle_expect.pop_front();
                for (int j = 0; j < jffd_pkg::ANGLE_FIELDS; j++)
                    if (seen.angle[j] !== want.angle[j])
                    begin
                        if (error_count < 10)
                            $display("angle_%0d mismatch at %0t: expected %0d, got %0d",
                                     j, $realtime, $signed(want.angle[j]),
                                     $signed(seen.angle[j]));
                        error_count++;
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin : stimulus
        angle_word_t ang;
        int unsigned src_pct [4];
        int unsigned rcv_pct [4];
        src_pct = '{0, 61, 0, 26};
        rcv_pct = '{0, 0, 61, 26};

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: a stray header among noise, then two frames back to back
        // carrying the extreme angle values, under the reset header.
        queue_byte(jffd_pkg::HEADER_RESET);
        queue_byte(8'h00);
        ang.angle = {16'h00FF, 16'h0080, 16'hFFFF, 16'h0000, 16'h7FFF, 16'h8000};
        queue_frame(header_reg, ang, 1'b1);
        ang.angle = {16'hFF00, 16'h0001, 16'hAAAA, 16'h5555, 16'h8000, 16'h7FFF};
        queue_frame(header_reg, ang, 1'b1);
        wait_drained();

        for (int p = 0; p < 4; p++)
        begin
            src_idle_pct = src_pct[p];
            rcv_stall_pct = rcv_pct[p];
            case (p)
                1: write_header(8'h00);
                2: write_header(8'hFF);
                3: write_header(jffd_pkg::byte_t'($urandom_range(254, 1)));
                default: ;
            endcase
            queue_random_traffic(PHASE_BYTES);
            wait_drained();
        end

        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
